/* src/stx_etx_escape_crc_deframer_assert.svh */
// Assertion macros shared by the deframer modules.
`ifndef STX_ETX_ESCAPE_CRC_DEFRAMER_ASSERT_SVH
`define STX_ETX_ESCAPE_CRC_DEFRAMER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SECD_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SECD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

/* src/secd_pkg.sv */
package secd_pkg;

    // Frame limit in collected bytes, check digits included.
    localparam int MAX_FRAME = 2048;
    localparam int LEN_W     = $clog2(MAX_FRAME + 1);

    // Hold-back line depth and the width of its fill count.
    localparam int HOLD_DEPTH = 4;
    localparam int FILL_W     = $clog2(HOLD_DEPTH + 1);
    localparam int HOLD_IDX_W = $clog2(HOLD_DEPTH);

    // Configuration port geometry.
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 2;
    localparam int ADDR_W    = REG_IDX_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_CRC_POLY    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CRC_INIT    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CRC_XOROUT  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_CRC_REFLECT = 2'd3;

    localparam logic [15:0] CRC_POLY_RESET    = 16'h8005;
    localparam logic [15:0] CRC_INIT_RESET    = 16'h0000;
    localparam logic [15:0] CRC_XOROUT_RESET  = 16'h0000;
    localparam logic        CRC_REFLECT_RESET = 1'b1;

    // Framing characters.
    localparam logic [7:0] BYTE_STX  = 8'd2;
    localparam logic [7:0] BYTE_ETX  = 8'd3;
    localparam logic [7:0] BYTE_ESC  = 8'd27;
    localparam logic [7:0] BYTE_DASH = 8'h2D;

    // End-of-frame status codes.
    localparam int STATUS_W = 3;
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BADCRC  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ABORT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERRUN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SHORT   = 3'd4;

    typedef enum logic [1:0] {
        MODE_HUNT    = 2'd0,
        MODE_COLLECT = 2'd1,
        MODE_ESCAPE  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [15:0] poly;
        logic [15:0] init;
        logic [15:0] xorout;
        logic        reflect;
    } cfg_t;

    typedef struct packed {
        logic [7:0]          payload_byte;
        logic                frame_end;
        logic [STATUS_W-1:0] frame_status;
    } res_t;

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

    function automatic logic [15:0] rev16(input logic [15:0] v);
        logic [15:0] r;
        for (int i = 0; i < 16; i++) begin
            r[i] = v[15 - i];
        end
        return r;
    endfunction

    // One byte through the MSB-first CRC-16 register.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data,
                                             input logic [15:0] poly, input logic reflect);
        logic [15:0] c;
        logic [7:0]  d;
        d = reflect ? rev8(data) : data;
        c = crc ^ {d, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // ASCII hex digit decode: bit 4 marks a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
        logic [4:0] r;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            r = {1'b1, 4'(ch - 8'h30)};
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            r = {1'b1, 4'(ch - 8'h37)};
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            r = {1'b1, 4'(ch - 8'h57)};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

endpackage

/* src/secd_apb_regs.sv */
module secd_apb_regs
    import secd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t                 cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Register writes complete in the access phase of a transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.poly    <= CRC_POLY_RESET;
            cfg_reg.init    <= CRC_INIT_RESET;
            cfg_reg.xorout  <= CRC_XOROUT_RESET;
            cfg_reg.reflect <= CRC_REFLECT_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CRC_POLY:    cfg_reg.poly    <= pwdata[15:0];
                REG_CRC_INIT:    cfg_reg.init    <= pwdata[15:0];
                REG_CRC_XOROUT:  cfg_reg.xorout  <= pwdata[15:0];
                REG_CRC_REFLECT: cfg_reg.reflect <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        unique case (reg_idx)
            REG_CRC_POLY:    prdata = {16'd0, cfg_reg.poly};
            REG_CRC_INIT:    prdata = {16'd0, cfg_reg.init};
            REG_CRC_XOROUT:  prdata = {16'd0, cfg_reg.xorout};
            REG_CRC_REFLECT: prdata = {31'd0, cfg_reg.reflect};
            default:         prdata = '0;
        endcase
    end

endmodule

/* src/secd_core.sv */
`include "stx_etx_escape_crc_deframer_assert.svh"

module secd_core
    import secd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output logic       res_valid,
    output res_t       res
);

    mode_t             mode_reg, mode_next;
    logic [7:0]        line_reg [HOLD_DEPTH];
    logic [7:0]        line_next [HOLD_DEPTH];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [15:0]       crc_reg, crc_next;

    logic        is_stx, is_etx, is_esc, is_ctrl;
    logic        in_collect, in_escape, in_hunt;
    logic        start_frame, abort, etx, take, overrun, accept, shift_out;
    logic        line_full;
    logic        all_dash, hex_ok;
    logic [15:0] msg, calc;
    logic [4:0]  nib [HOLD_DEPTH];
    logic [STATUS_W-1:0] end_status;

    // Byte classification and decode of the current transfer.
    assign is_stx     = rx_byte == BYTE_STX;
    assign is_etx     = rx_byte == BYTE_ETX;
    assign is_esc     = rx_byte == BYTE_ESC;
    assign is_ctrl    = is_stx || is_etx || is_esc;
    assign in_collect = mode_reg == MODE_COLLECT;
    assign in_escape  = mode_reg == MODE_ESCAPE;
    assign in_hunt    = !in_collect && !in_escape;
    assign line_full  = fill_reg == FILL_W'(HOLD_DEPTH);

    assign abort       = step && in_collect && is_stx;
    assign start_frame = step && is_stx && (in_collect || in_hunt);
    assign etx         = step && in_collect && is_etx;
    assign take        = step && (in_escape || (in_collect && !is_ctrl));
    assign overrun     = take && (len_reg >= LEN_W'(MAX_FRAME));
    assign accept      = take && !overrun;
    assign shift_out   = accept && line_full;

    // Check field decode: dashes, four hex digits, and the CRC to compare.
    always_comb begin
        all_dash = 1'b1;
        hex_ok   = 1'b1;
        for (int i = 0; i < HOLD_DEPTH; i++) begin
            nib[i]   = hex_nibble(line_reg[i]);
            all_dash = all_dash && (line_reg[i] == BYTE_DASH);
            hex_ok   = hex_ok && nib[i][4];
        end
        msg  = {nib[0][3:0], nib[1][3:0], nib[2][3:0], nib[3][3:0]};
        calc = (cfg.reflect ? rev16(crc_reg) : crc_reg) ^ cfg.xorout;
        if (!line_full) begin
            end_status = ST_SHORT;
        end else if (all_dash) begin
            end_status = ST_OK;
        end else if (!hex_ok) begin
            end_status = ST_BADCRC;
        end else begin
            end_status = (msg == calc) ? ST_OK : ST_BADCRC;
        end
    end

    // Next parse mode.
    always_comb begin
        mode_next = mode_reg;
        if (step) begin
            unique case (mode_reg)
                MODE_COLLECT: begin
                    if (is_stx) begin
                        mode_next = MODE_COLLECT;
                    end else if (is_etx) begin
                        mode_next = MODE_HUNT;
                    end else if (is_esc) begin
                        mode_next = MODE_ESCAPE;
                    end else if (overrun) begin
                        mode_next = MODE_HUNT;
                    end
                end
                MODE_ESCAPE: begin
                    mode_next = overrun ? MODE_HUNT : MODE_COLLECT;
                end
                default: begin
                    mode_next = is_stx ? MODE_COLLECT : MODE_HUNT;
                end
            endcase
        end
    end

    // Result and datapath updates.
    always_comb begin
        line_next = line_reg;
        fill_next = fill_reg;
        len_next  = len_reg;
        crc_next  = crc_reg;
        res_valid = abort || etx || overrun || shift_out;
        res       = '0;
        priority if (abort) begin
            res.frame_end    = 1'b1;
            res.frame_status = ST_ABORT;
        end else if (etx) begin
            res.frame_end    = 1'b1;
            res.frame_status = end_status;
        end else if (overrun) begin
            res.frame_end    = 1'b1;
            res.frame_status = ST_OVERRUN;
        end else if (shift_out) begin
            res.payload_byte = line_reg[0];
        end else begin
            res = '0;
        end
        if (start_frame) begin
            for (int i = 0; i < HOLD_DEPTH; i++) begin
                line_next[i] = 8'd0;
            end
            fill_next = '0;
            len_next  = '0;
            crc_next  = cfg.init;
        end else if (accept) begin
            len_next = len_reg + 1'b1;
            if (line_full) begin
                for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
                    line_next[i] = line_reg[i + 1];
                end
                line_next[HOLD_DEPTH - 1] = rx_byte;
                crc_next = crc_byte(crc_reg, line_reg[0], cfg.poly, cfg.reflect);
            end else begin
                line_next[fill_reg[HOLD_IDX_W-1:0]] = rx_byte;
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_HUNT;
            fill_reg <= '0;
            len_reg  <= '0;
        end else begin
            mode_reg <= mode_next;
            fill_reg <= fill_next;
            len_reg  <= len_next;
        end
    end

    // Hold-back bytes and running CRC.
    always_ff @(posedge aclk) begin
        line_reg <= line_next;
        crc_reg  <= crc_next;
    end

    `SECD_ASSERT_SAME(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= FILL_W'(HOLD_DEPTH))
    `SECD_ASSERT_SAME(a_len_bound, aclk, aresetn, 1'b1, len_reg <= LEN_W'(MAX_FRAME))
    `SECD_ASSERT_SAME(a_payload_full, aclk, aresetn, res_valid && !res.frame_end, line_full)

endmodule

/* src/stx_etx_escape_crc_deframer.sv */
// STX/ETX byte-stuffed frame receiver with a configurable CRC-16 check.
// Raw serial bytes arrive on the s_ channel (s_valid, s_ready, s_rx_byte).
// Results leave on the m_ channel: a payload byte (m_frame_end low) or an
// end-of-frame status (m_frame_end high, m_frame_status: 0 ok, 1 CRC
// mismatch or bad hex, 2 aborted, 3 overrun, 4 too short).
// The CRC registers sit on the APB port: poly at 0x0, init at 0x4, xorout
// at 0x8, reflect at 0xC. Write them only while no frame is in flight.
// Each accepted byte is held in an input register, decoded combinationally,
// and any result lands in the output register, from which it appears on
// the m_ channel. One byte is taken every cycle while m_ready keeps the
// output register free; the byte-wide CRC update and the check field
// decode set the clock path.
// Payload bytes trail the line by four bytes, since the last four bytes of
// a frame are the check digits.
// Reset returns the parser to hunting for STX and loads the register
// defaults (poly 0x8005, init 0, xorout 0, reflect 1).
// When the receiver stalls, the output register holds its result and one
// more byte can wait in the input register; s_ready then drops.
`include "stx_etx_escape_crc_deframer_assert.svh"

module stx_etx_escape_crc_deframer
    import secd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_payload_byte,
    output logic                m_frame_end,
    output logic [STATUS_W-1:0] m_frame_status
);

    cfg_t       cfg;
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    res_t       out_res_reg;
    logic       out_free, advance, core_valid;
    res_t       core_res;

    secd_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    secd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg),
        .res_valid (core_valid),
        .res       (core_res)
    );

    // The held byte moves on whenever the output register can take a result.
    assign out_free       = !out_valid_reg || m_ready;
    assign advance        = in_valid_reg && out_free;
    assign s_ready        = !in_valid_reg || advance;
    assign in_valid_next  = s_valid && s_ready ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = out_free ? (advance && core_valid) : out_valid_reg;

    // Handshake state for both registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of the input and output registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (advance && core_valid) begin
            out_res_reg <= core_res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_payload_byte = out_res_reg.payload_byte;
    assign m_frame_end    = out_res_reg.frame_end;
    assign m_frame_status = out_res_reg.frame_status;

    `SECD_ASSERT_SAME(a_payload_status, aclk, aresetn,
                      m_valid && !m_frame_end, m_frame_status == ST_OK)
    `SECD_ASSERT_SAME(a_end_no_byte, aclk, aresetn,
                      m_valid && m_frame_end, m_payload_byte == 8'd0)
    `SECD_ASSERT_NEXT(a_in_hold, aclk, aresetn,
                      in_valid_reg && !advance, in_valid_reg && $stable(in_byte_reg))

endmodule

/* dv/stx_etx_escape_crc_deframer_tb.sv */
`timescale 1ns / 100ps

module stx_etx_escape_crc_deframer_tb
    import secd_pkg::*;
();

    localparam int HALF_PERIOD   = 2;
    localparam int ITEM_TARGET   = 1000;
    localparam int PHASES        = 5;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 1000;

    typedef enum {
        FRAME_GOOD,
        FRAME_DASHES,
        FRAME_BADCRC,
        FRAME_BADHEX,
        FRAME_SHORT,
        FRAME_ABORT,
        FRAME_NOISE
    } frame_kind_t;

    // Tracks the deframer state and the results each received byte must produce.
    class deframer_scoreboard;
        logic [15:0] poly;
        logic [15:0] init_val;
        logic [15:0] xorout;
        logic        reflect;

        mode_t       mode;
        logic [7:0]  hold[HOLD_DEPTH];
        int          fill;
        logic [15:0] crc;
        int          frame_len;

        res_t        awaited_results[$];
        int          errors;
        int          bytes_in;
        int          payload_count;
        int          status_count[8];

        function new();
            poly      = CRC_POLY_RESET;
            init_val  = CRC_INIT_RESET;
            xorout    = CRC_XOROUT_RESET;
            reflect   = CRC_REFLECT_RESET;
            mode      = MODE_HUNT;
            fill      = 0;
            crc       = CRC_INIT_RESET;
            frame_len = 0;
            foreach (hold[i]) hold[i] = 8'h00;
            foreach (status_count[i]) status_count[i] = 0;
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_CRC_POLY:    poly = value[15:0];
                REG_CRC_INIT:    init_val = value[15:0];
                REG_CRC_XOROUT:  xorout = value[15:0];
                REG_CRC_REFLECT: reflect = value[0];
                default: ;
            endcase
        endfunction

        function logic [DATA_W-1:0] read_reg(logic [REG_IDX_W-1:0] idx);
            case (idx)
                REG_CRC_POLY:    return DATA_W'(poly);
                REG_CRC_INIT:    return DATA_W'(init_val);
                REG_CRC_XOROUT:  return DATA_W'(xorout);
                default:         return DATA_W'(reflect);
            endcase
        endfunction

        // One byte into the CRC register, shifted MSB first.
        function logic [15:0] crc_step(logic [15:0] acc, logic [7:0] data);
            logic [15:0] c;
            logic [7:0]  d;
            if (reflect) begin
                d = {<<{data}};
            end else begin
                d = data;
            end
            c = acc ^ {d, 8'h00};
            for (int i = 0; i < 8; i++) begin
                if (c[15]) begin
                    c = (c << 1) ^ poly;
                end else begin
                    c = c << 1;
                end
            end
            return c;
        endfunction

        // Value the check digits must spell for a given register content.
        function logic [15:0] crc_final(logic [15:0] acc);
            logic [15:0] r;
            if (reflect) begin
                r = {<<{acc}};
            end else begin
                r = acc;
            end
            return r ^ xorout;
        endfunction

        function logic [15:0] check_value(logic [7:0] data[$]);
            logic [15:0] acc;
            acc = init_val;
            foreach (data[i]) acc = crc_step(acc, data[i]);
            return crc_final(acc);
        endfunction

        function int digit_of(logic [7:0] ch);
            if (ch >= "0" && ch <= "9") return int'(ch - "0");
            if (ch >= "A" && ch <= "F") return int'(ch - "A") + 10;
            if (ch >= "a" && ch <= "f") return int'(ch - "a") + 10;
            return -1;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function void push_end(logic [STATUS_W-1:0] status);
            res_t r;
            r.payload_byte = 8'h00;
            r.frame_end    = 1'b1;
            r.frame_status = status;
            awaited_results.push_back(r);
        endfunction

        function void start_frame();
            foreach (hold[i]) hold[i] = 8'h00;
            fill      = 0;
            frame_len = 0;
            crc       = init_val;
            mode      = MODE_COLLECT;
        endfunction

        // Status at ETX: the four held bytes are the check field.
        function logic [STATUS_W-1:0] close_status();
            logic [15:0] digits;
            int          v;
            if (fill < HOLD_DEPTH) return ST_SHORT;
            if (hold[0] == BYTE_DASH && hold[1] == BYTE_DASH &&
                hold[2] == BYTE_DASH && hold[3] == BYTE_DASH) return ST_OK;
            digits = 16'h0000;
            for (int i = 0; i < HOLD_DEPTH; i++) begin
                v = digit_of(hold[i]);
                if (v < 0) return ST_BADCRC;
                digits = {digits[11:0], v[3:0]};
            end
            return (digits == crc_final(crc)) ? ST_OK : ST_BADCRC;
        endfunction

        // A frame byte enters the hold-back line; the oldest one leaves as payload.
        function void collect_byte(logic [7:0] b);
            logic [7:0] oldest;
            res_t       r;
            if (frame_len >= MAX_FRAME) begin
                mode = MODE_HUNT;
                push_end(ST_OVERRUN);
                return;
            end
            frame_len++;
            if (fill < HOLD_DEPTH) begin
                hold[fill] = b;
                fill++;
                return;
            end
            oldest  = hold[0];
            hold[0] = hold[1];
            hold[1] = hold[2];
            hold[2] = hold[3];
            hold[3] = b;
            crc = crc_step(crc, oldest);
            r.payload_byte = oldest;
            r.frame_end    = 1'b0;
            r.frame_status = ST_OK;
            awaited_results.push_back(r);
        endfunction

        // Called for every transfer accepted on the input channel.
        function void accept_rx_byte(logic [7:0] b);
            bytes_in++;
            case (mode)
                MODE_COLLECT: begin
                    if (b == BYTE_STX) begin
                        start_frame();
                        push_end(ST_ABORT);
                    end else if (b == BYTE_ETX) begin
                        push_end(close_status());
                        mode = MODE_HUNT;
                    end else if (b == BYTE_ESC) begin
                        mode = MODE_ESCAPE;
                    end else begin
                        collect_byte(b);
                    end
                end
                MODE_ESCAPE: begin
                    mode = MODE_COLLECT;
                    collect_byte(b);
                end
                default: begin
                    if (b == BYTE_STX) start_frame();
                end
            endcase
        endfunction

        // Called for every transfer accepted on the result channel.
        function void check_result(res_t got);
            res_t want;
            if (awaited_results.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: byte %02h end %0b status %0d",
                         $time, got.payload_byte, got.frame_end, got.frame_status);
                return;
            end
            want = awaited_results.pop_front();
            if (got.frame_end != want.frame_end) begin
                errors++;
                $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                         $time, want.frame_end, got.frame_end);
            end
            if (got.payload_byte != want.payload_byte) begin
                errors++;
                $display("%0t: payload_byte mismatch, expected %02h, actual %02h",
                         $time, want.payload_byte, got.payload_byte);
            end
            if (got.frame_status != want.frame_status) begin
                errors++;
                $display("%0t: frame_status mismatch, expected %0d, actual %0d",
                         $time, want.frame_status, got.frame_status);
            end
            if (want.frame_end) begin
                status_count[want.frame_status]++;
            end else begin
                payload_count++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    logic [7:0]          s_rx_byte;
    logic                m_valid;
    logic                m_ready;
    logic [7:0]          m_payload_byte;
    logic                m_frame_end;
    logic [STATUS_W-1:0] m_frame_status;

    deframer_scoreboard sb;
    logic [7:0]         outgoing[$];
    int                 burst_left;
    bit                 sender_steady;
    int                 ready_left;
    int                 stall_left;
    int                 quiet_cycles;
    int                 frame_bytes;
    int                 settings_used;

    stx_etx_escape_crc_deframer i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload_byte (m_payload_byte),
        .m_frame_end    (m_frame_end),
        .m_frame_status (m_frame_status)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Sample both channels at the rising edge and watch for a stuck block.
    always @(posedge aclk) begin
        res_t seen;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.accept_rx_byte(s_rx_byte);
            end
            if (m_valid && m_ready) begin
                seen.payload_byte = m_payload_byte;
                seen.frame_end    = m_frame_end;
                seen.frame_status = m_frame_status;
                sb.check_result(seen);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("stx_etx_escape_crc_deframer verification failed");
                $finish;
            end
        end
    end

    // The receiver alternates ready runs with stalls, with the odd long ready stretch.
    always @(negedge aclk) begin
        if (stall_left == 0 && ready_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
                ready_left = $urandom_range(100, 300);
                stall_left = 0;
            end else begin
                ready_left = $urandom_range(1, 20);
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24)
                                                         : $urandom_range(0, 6);
            end
        end
        if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else begin
            m_ready = 1'b1;
            ready_left--;
        end
    end

    // One byte transfer; the sender idles between bursts unless running steady.
    task automatic send_byte(input logic [7:0] b);
        if (burst_left == 0) begin
            if (!sender_steady) begin
                s_valid = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_valid   = 1'b1;
        s_rx_byte = b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_outgoing();
        foreach (outgoing[i]) send_byte(outgoing[i]);
        outgoing.delete();
    endtask

    // Hold off until every expected result is out and the pipeline is empty.
    task automatic settle();
        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Terminate any frame still open so that the block is hunting.
    task automatic close_frame();
        while (sb.mode != MODE_HUNT) send_byte(BYTE_ETX);
    endtask

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.write_reg(idx, value);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic reg_check(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] mask);
        logic [DATA_W-1:0] want;
        want    = sb.read_reg(idx) & mask;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if ((prdata & mask) != want) begin
            sb.errors++;
            $display("%0t: register %0d readback mismatch, expected %08h, actual %08h",
                     $time, idx, want, prdata & mask);
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic apply_crc_setting(input logic [15:0] poly, input logic [15:0] init_val,
                                     input logic [15:0] xorout, input logic reflect);
        reg_write(REG_CRC_POLY, DATA_W'(poly));
        reg_write(REG_CRC_INIT, DATA_W'(init_val));
        reg_write(REG_CRC_XOROUT, DATA_W'(xorout));
        reg_write(REG_CRC_REFLECT, DATA_W'(reflect));
        reg_check(REG_CRC_POLY, 32'h0000_FFFF);
        reg_check(REG_CRC_INIT, 32'h0000_FFFF);
        reg_check(REG_CRC_XOROUT, 32'h0000_FFFF);
        reg_check(REG_CRC_REFLECT, 32'h0000_0001);
        settings_used++;
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
        logic [7:0] base;
        if (n < 10) begin
            base = "0";
        end else if (upper) begin
            base = "A" - 8'd10;
        end else begin
            base = "a" - 8'd10;
        end
        return base + 8'(n);
    endfunction

    function automatic logic [7:0] byte_except_stx();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == BYTE_STX) ? 8'h55 : b;
    endfunction

    // Framing bytes must be escaped; ordinary bytes are sometimes escaped too.
    function automatic void push_data(logic [7:0] b);
        if (b == BYTE_STX || b == BYTE_ETX || b == BYTE_ESC || $urandom_range(0, 9) == 0) begin
            outgoing.push_back(BYTE_ESC);
        end
        outgoing.push_back(b);
    endfunction

    // Four hex digits, mixed case; a non-negative bad_pos spoils that digit.
    function automatic void push_check(logic [15:0] chk, int bad_pos);
        logic [7:0] c;
        for (int k = 0; k < 4; k++) begin
            c = hex_char(chk[(3 - k) * 4 +: 4], bit'($urandom_range(0, 1)));
            if (k == bad_pos) begin
                do begin
                    c = 8'($urandom_range(0, 255));
                end while (sb.digit_of(c) >= 0);
            end
            push_data(c);
        end
    endfunction

    function automatic frame_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return FRAME_GOOD;
        if (r < 60) return FRAME_DASHES;
        if (r < 68) return FRAME_BADCRC;
        if (r < 75) return FRAME_BADHEX;
        if (r < 83) return FRAME_SHORT;
        if (r < 91) return FRAME_ABORT;
        return FRAME_NOISE;
    endfunction

    function automatic void build_frame(frame_kind_t kind);
        logic [7:0]  payload[$];
        logic [7:0]  b;
        logic [15:0] chk;
        int          n;
        if (kind == FRAME_NOISE) begin
            repeat ($urandom_range(1, 6)) outgoing.push_back(byte_except_stx());
            return;
        end
        outgoing.push_back(BYTE_STX);
        if (kind == FRAME_SHORT) begin
            n = $urandom_range(0, 3);
        end else if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(13, 40);
        end else begin
            n = $urandom_range(0, 12);
        end
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            payload.push_back(b);
            push_data(b);
        end
        chk = sb.check_value(payload);
        case (kind)
            FRAME_GOOD:   push_check(chk, -1);
            FRAME_BADCRC: push_check(chk ^ (16'h0001 << $urandom_range(0, 15)), -1);
            FRAME_BADHEX: push_check(chk, $urandom_range(0, 3));
            FRAME_DASHES: repeat (4) push_data(BYTE_DASH);
            default: ;
        endcase
        if (kind != FRAME_ABORT) outgoing.push_back(BYTE_ETX);
    endfunction

    // A frame of the given collected length; past the limit it is cut off as overrun.
    function automatic void build_long_frame(int collected, bit overrun);
        logic [7:0] payload[$];
        logic [7:0] b;
        outgoing.push_back(BYTE_STX);
        for (int i = 0; i < (overrun ? collected : collected - 4); i++) begin
            b = byte_except_stx();
            payload.push_back(b);
            push_data(b);
        end
        if (!overrun) push_check(sb.check_value(payload), -1);
        outgoing.push_back(BYTE_ETX);
    endfunction

    initial begin
        logic [7:0]  payload[$];
        frame_kind_t kind;

        aclk          = 1'b0;
        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_valid       = 1'b0;
        s_rx_byte     = 8'h00;
        m_ready       = 1'b0;
        burst_left    = 0;
        sender_steady = 1'b0;
        ready_left    = 0;
        stall_left    = 0;
        quiet_cycles  = 0;
        frame_bytes   = 0;
        settings_used = 1;
        sb = new();

        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: noise while hunting, escaped framing bytes and byte extremes,
        // an abort followed by a "----" frame, and an empty frame.
        outgoing = '{8'hFF, 8'h00, BYTE_ETX, BYTE_ESC, BYTE_STX,
                     BYTE_ESC, BYTE_STX, BYTE_ESC, BYTE_ETX, BYTE_ESC, BYTE_ESC,
                     8'hFF, 8'h00};
        payload = '{BYTE_STX, BYTE_ETX, BYTE_ESC, 8'hFF, 8'h00};
        push_check(sb.check_value(payload), -1);
        outgoing.push_back(BYTE_ETX);
        outgoing.push_back(BYTE_STX);
        outgoing.push_back("A");
        outgoing.push_back(BYTE_STX);
        repeat (4) outgoing.push_back(BYTE_DASH);
        outgoing.push_back(BYTE_ETX);
        outgoing.push_back(BYTE_STX);
        outgoing.push_back(BYTE_ETX);
        send_outgoing();
        settle();

        // Random frames, one CRC setting per phase.
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                close_frame();
                settle();
                case (phase)
                    1: apply_crc_setting(16'h1021, 16'hFFFF, 16'h0000, 1'b0);
                    2: apply_crc_setting(16'h0000, 16'h0000, 16'h0000, 1'b0);
                    3: apply_crc_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
                    default: apply_crc_setting(16'($urandom), 16'($urandom),
                                               16'($urandom), 1'($urandom));
                endcase
            end
            if (phase == 1) begin
                // A frame exactly at the limit, then one that runs past it.
                sender_steady = 1'b0;
                build_long_frame(MAX_FRAME, 1'b0);
                send_outgoing();
                build_long_frame(MAX_FRAME + 1 + $urandom_range(0, 5), 1'b1);
                send_outgoing();
            end
            while (frame_bytes < (phase + 1) * ITEM_TARGET / PHASES) begin
                kind = pick_kind();
                sender_steady = ($urandom_range(0, 4) == 0);
                build_frame(kind);
                if (kind != FRAME_NOISE) frame_bytes += outgoing.size();
                send_outgoing();
            end
        end
        close_frame();
        settle();

        $display("Run covered %0d input bytes, %0d payload bytes out and %0d CRC settings.",
                 sb.bytes_in, sb.payload_count, settings_used);
        $display("Frame ends: %0d ok, %0d bad check, %0d aborted, %0d overrun, %0d short.",
                 sb.status_count[ST_OK], sb.status_count[ST_BADCRC],
                 sb.status_count[ST_ABORT], sb.status_count[ST_OVERRUN],
                 sb.status_count[ST_SHORT]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("stx_etx_escape_crc_deframer verification clean");
        end else begin
            $display("stx_etx_escape_crc_deframer verification failed");
        end
        $finish;
    end

endmodule
